[src/wbps_pkg.sv]
package wbps_pkg;

  // Field widths of the stream words
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned ADDR_W        = 47;
  localparam int unsigned COUNT_W       = 16;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned MASK_W        = 32;
  localparam int unsigned PATTERN_BYTES = 32;
  localparam int unsigned POS_W         = 5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [LEN_W-1:0]   len_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_0      = 3'd0,
    REG_PATTERN_1      = 3'd1,
    REG_PATTERN_2      = 3'd2,
    REG_PATTERN_3      = 3'd3,
    REG_WILDCARD_MASK  = 3'd4,
    REG_PATTERN_LENGTH = 3'd5
  } cfg_reg_e;

  localparam count_t COUNT_MAX = '1;

endpackage

[src/wbps_if.sv]
// Input channel: one memory byte with its address
interface wbps_in_if;
  logic                 valid;
  logic                 ready;
  wbps_pkg::byte_t      data_byte;
  wbps_pkg::addr_t      byte_address;
  logic                 region_first;

  modport source (output valid, data_byte, byte_address, region_first, input ready);
  modport sink   (input valid, data_byte, byte_address, region_first, output ready);
endinterface

// Output channel: one match report
interface wbps_out_if;
  logic                 valid;
  logic                 ready;
  wbps_pkg::addr_t      match_address;
  wbps_pkg::count_t     match_number;

  modport source (output valid, match_address, match_number, input ready);
  modport sink   (input valid, match_address, match_number, output ready);
endinterface

[src/wildcard_byte_pattern_search_unit.sv]
// Wildcard byte signature scanner. Takes one memory byte per word on in_i, with its
// address and a region-start flag, and reports on out_o the start address and a
// saturating running number of every match of the configured pattern (up to
// MAX_PATTERN bytes, any position may be a wildcard). Matches never overlap and
// never span a region break. Throughput is one byte per cycle while out_o is ready;
// a byte passes an input register and then a result register before its match
// shows on out_o. The window compare runs against a copy of the pattern realigned
// to the configured length, registered from the configuration registers. Write
// configuration only while the scanner is idle.
module wildcard_byte_pattern_search_unit #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  wbps_in_if.sink                              in_i,
  wbps_out_if.source                           out_o
);

  localparam int unsigned CntW = $clog2(MAX_PATTERN + 1);

  // Configuration registers
  logic [wbps_pkg::CFG_DATA_W-1:0] pattern_q [4];
  logic [wbps_pkg::MASK_W-1:0]     wildcard_q;
  wbps_pkg::len_t                  plen_q;

  // Pattern realigned to window slots: slot k holds pattern position len-1-k
  wbps_pkg::byte_t                 cmp_byte_q [MAX_PATTERN];
  wbps_pkg::byte_t                 cmp_byte_d [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]          cmp_care_q, cmp_care_d;
  wbps_pkg::len_t                  len_q, len_d;
  wbps_pkg::len_t                  len_m1_q;

  // Input register
  logic                            s1_valid_q;
  wbps_pkg::byte_t                 s1_byte_q;
  wbps_pkg::addr_t                 s1_addr_q;
  logic                            s1_first_q;

  // Scan state
  wbps_pkg::byte_t                 win_q [MAX_PATTERN];
  wbps_pkg::byte_t                 win_d [MAX_PATTERN];
  logic [CntW-1:0]                 fill_q, fill_d, fill_base, fill_inc;
  wbps_pkg::count_t                total_q, total_d;

  // Result register
  logic                            out_valid_q;
  wbps_pkg::addr_t                 match_addr_q;
  wbps_pkg::count_t                match_num_q;

  logic                            can_adv;
  logic                            proc;
  logic                            in_fire;
  logic                            hit;
  logic [MAX_PATTERN-1:0]          slot_ok;
  wbps_pkg::byte_t                 pat_flat [wbps_pkg::PATTERN_BYTES];
  wbps_pkg::len_t                  pos;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < 4; w++) begin
        pattern_q[w] <= '0;
      end
      wildcard_q <= '0;
      plen_q     <= wbps_pkg::len_t'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wbps_pkg::REG_PATTERN_0:      pattern_q[0] <= cfg_data_i;
        wbps_pkg::REG_PATTERN_1:      pattern_q[1] <= cfg_data_i;
        wbps_pkg::REG_PATTERN_2:      pattern_q[2] <= cfg_data_i;
        wbps_pkg::REG_PATTERN_3:      pattern_q[3] <= cfg_data_i;
        wbps_pkg::REG_WILDCARD_MASK:  wildcard_q   <= cfg_data_i[wbps_pkg::MASK_W-1:0];
        wbps_pkg::REG_PATTERN_LENGTH: plen_q       <= cfg_data_i[wbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length and realign pattern and care bits to window slots
  always_comb begin
    for (int b = 0; b < wbps_pkg::PATTERN_BYTES; b++) begin
      pat_flat[b] = pattern_q[b / 8][(b % 8) * 8 +: 8];
    end
    if (plen_q == '0) begin
      len_d = wbps_pkg::len_t'(1);
    end else if (plen_q > wbps_pkg::len_t'(MAX_PATTERN)) begin
      len_d = wbps_pkg::len_t'(MAX_PATTERN);
    end else begin
      len_d = plen_q;
    end
    pos = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pos           = wbps_pkg::len_t'(len_d - wbps_pkg::len_t'(1) - wbps_pkg::len_t'(k));
      cmp_byte_d[k] = pat_flat[pos[wbps_pkg::POS_W-1:0]];
      cmp_care_d[k] = (wbps_pkg::len_t'(k) < len_d) && !wildcard_q[pos[wbps_pkg::POS_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_care_q <= MAX_PATTERN'(1);
      len_q      <= wbps_pkg::len_t'(1);
      len_m1_q   <= '0;
    end else begin
      cmp_care_q <= cmp_care_d;
      len_q      <= len_d;
      len_m1_q   <= wbps_pkg::len_t'(len_d - wbps_pkg::len_t'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      cmp_byte_q[k] <= cmp_byte_d[k];
    end
  end

  // Handshake: the input stage drains whenever the result register can take a word
  assign can_adv     = !out_valid_q || out_o.ready;
  assign proc        = s1_valid_q && can_adv;
  assign in_i.ready  = !s1_valid_q || can_adv;
  assign in_fire     = in_i.valid && in_i.ready;

  // Hold the accepted word in the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q  <= in_i.data_byte;
      s1_addr_q  <= in_i.byte_address;
      s1_first_q <= in_i.region_first;
    end
  end

  // Shift the byte into the window and compare all slots at once
  always_comb begin
    win_d[0] = s1_byte_q;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_d[k] = win_q[k-1];
    end
    fill_base = s1_first_q ? '0 : fill_q;
    fill_inc  = (fill_base < CntW'(MAX_PATTERN)) ? CntW'(fill_base + 1'b1) : fill_base;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      slot_ok[k] = !cmp_care_q[k] || (win_d[k] == cmp_byte_q[k]);
    end
    hit     = (&slot_ok) && (wbps_pkg::len_t'(fill_inc) >= len_q);
    fill_d  = hit ? '0 : fill_inc;
    total_d = (total_q == wbps_pkg::COUNT_MAX) ? total_q : wbps_pkg::count_t'(total_q + 1'b1);
  end

  // Advance scan state and load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (proc) begin
        fill_q <= fill_d;
        if (hit) begin
          total_q <= total_d;
        end
      end
      if (can_adv) begin
        out_valid_q <= proc && hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_q[k] <= win_d[k];
      end
      if (hit) begin
        match_addr_q <= s1_addr_q -
                        {{(wbps_pkg::ADDR_W - wbps_pkg::LEN_W){1'b0}}, len_m1_q};
        match_num_q  <= total_d;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.match_address = match_addr_q;
  assign out_o.match_number  = match_num_q;

endmodule
